/* sv/lfst_pkg.sv */
package lfst_pkg;

    localparam int MAX_SEGMENTS     = 4096;
    localparam int SEG_AW           = $clog2(MAX_SEGMENTS);
    localparam int COUNT_W          = SEG_AW + 1;
    localparam int NUM_STRIPS       = 64;
    localparam int PIXELS_PER_STRIP = 600;
    localparam int PAINT_W          = 10;
    localparam int HEADER_BYTES     = 8 + 8 + 8;
    localparam int BYTES_PER_PIXEL  = 3;

    localparam logic [55:0] TAG_WORD    = 56'h4C65644275726E;
    localparam logic [15:0] STALE_RESET = 16'd500;

    // Divide by three: q = (x * DIV3_MUL) >> DIV3_SHIFT, exact for any 16-bit x
    localparam logic [16:0] DIV3_MUL   = 17'd43691;
    localparam int          DIV3_SHIFT = 17;
    localparam int          NPIX_W     = 15;

    // Bitmap entries carry the epoch of the frame that set them; zero means clear
    localparam int         EPOCH_W     = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    // Sweep once the epoch gets this high; the pass waits for an empty bitmap or runs
    // ahead of a resync, so the epoch climbs at most one more step before it
    localparam logic [EPOCH_W-1:0] EPOCH_LIMIT = {EPOCH_W{1'b1}} - EPOCH_W'(2);

    localparam int         APB_AW        = 3;
    localparam logic [0:0] REG_STALE_WIN = 1'b0;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_MALFORMED   = 2'd1,
        ST_BAD_SEGMENT = 2'd2,
        ST_STALE       = 2'd3
    } status_t;

    typedef struct packed {
        logic [55:0] magic_tag;
        logic [7:0]  version;
        logic [15:0] packet_length;
        logic [31:0] frame_id;
        logic [31:0] segment_total;
        logic [31:0] segment_index;
        logic [15:0] strip_number;
        logic [15:0] first_pixel;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic               flush_before;
        logic               paint_enable;
        logic [15:0]        paint_strip;
        logic [15:0]        paint_start;
        logic [PAINT_W-1:0] paint_count;
        logic               duplicate;
        logic               frame_complete;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic sweep_wr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic sweep_first;
        logic sweep_last;
    } dp_status_t;

    typedef enum logic [1:0] {
        S_SWEEP      = 2'd0,
        S_IDLE       = 2'd1,
        S_LOOK       = 2'd2,
        S_HOLD_SWEEP = 2'd3
    } state_t;

endpackage

/* sv/lfst_ram.sv */
module lfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/lfst_ctrl.sv */
module lfst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  lfst_pkg::dp_status_t dp_status,
    output lfst_pkg::ctrl_cmd_t  cmd
);

    import lfst_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (dp_status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (dp_status.need_sweep)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                // clear the bitmap first when this header resyncs at a high epoch
                if (dp_status.sweep_first)
                begin
                    state_next = S_HOLD_SWEEP;
                end
                // hold the item until the output register is free
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_HOLD_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (dp_status.sweep_last)
                begin
                    state_next = S_LOOK;
                end
            end
            default:
            begin
                state_next = S_SWEEP;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/lfst_datapath.sv */
module lfst_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfst_pkg::in_item_t   in_data,
    input  logic [15:0]          stale_window,
    input  lfst_pkg::ctrl_cmd_t  cmd,
    output lfst_pkg::dp_status_t dp_status,
    output lfst_pkg::out_item_t  out_data
);

    import lfst_pkg::*;

    in_item_t           in_reg;
    logic [NPIX_W-1:0]  npix_reg;
    logic [31:0]        cur_frame_reg, cur_frame_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [SEG_AW-1:0]  sweep_addr_reg;
    out_item_t          out_reg;

    logic [15:0]        in_payload;
    logic [32:0]        div_prod;
    logic [EPOCH_W-1:0] ram_rdata;
    logic               ram_we;
    logic [SEG_AW-1:0]  ram_waddr;
    logic [EPOCH_W-1:0] ram_wdata;

    logic [15:0]        payload_bytes;
    logic [NPIX_W+1:0]  npix_times3;
    logic               malformed, bad_seg, other_frame, stale, resync;
    logic [31:0]        behind;
    logic [EPOCH_W-1:0] epoch_a;
    logic [COUNT_W-1:0] count_a, count_b;
    logic               seen, complete;
    logic               in_range;
    logic [PAINT_W-1:0] room, cnt;
    logic               sweep_first;
    out_item_t          result;

    // quotient of the payload length by three, taken straight off the port
    assign in_payload = in_data.packet_length - 16'(HEADER_BYTES);
    assign div_prod   = {17'd0, in_payload} * {16'd0, DIV3_MUL};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg   <= in_data;
            npix_reg <= div_prod[DIV3_SHIFT +: NPIX_W];
        end
        if (cmd.commit)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_frame_reg  <= '0;
            count_reg      <= '0;
            epoch_reg      <= EPOCH_FIRST;
            sweep_addr_reg <= '0;
        end
        else
        begin
            cur_frame_reg <= cur_frame_next;
            count_reg     <= count_next;
            epoch_reg     <= epoch_next;
            if (cmd.sweep_wr)
            begin
                sweep_addr_reg <= sweep_addr_reg + SEG_AW'(1);
            end
        end
    end

    always_comb
    begin
        payload_bytes = in_reg.packet_length - 16'(HEADER_BYTES);
        npix_times3   = (NPIX_W+2)'(npix_reg) * (NPIX_W+2)'(BYTES_PER_PIXEL);
        malformed     = (in_reg.packet_length < 16'(HEADER_BYTES))
                     || (in_reg.magic_tag != TAG_WORD)
                     || (in_reg.version != 8'd0)
                     || (npix_times3 != (NPIX_W+2)'(payload_bytes));
        bad_seg       = (in_reg.segment_total >= 32'(MAX_SEGMENTS))
                     || (in_reg.segment_index >= in_reg.segment_total);

        other_frame = in_reg.frame_id != cur_frame_reg;
        behind      = cur_frame_reg - in_reg.frame_id;
        stale       = other_frame && (in_reg.frame_id < cur_frame_reg)
                   && (behind < {16'd0, stale_window});
        resync      = other_frame;

        // a resync clears the bitmap by moving to a fresh epoch
        epoch_a  = resync ? epoch_reg + EPOCH_W'(1) : epoch_reg;
        count_a  = resync ? '0 : count_reg;
        count_b  = count_a + COUNT_W'(1);
        seen     = !resync && (ram_rdata == epoch_reg);
        complete = !seen && (count_b >= in_reg.segment_total[COUNT_W-1:0]);

        in_range = (in_reg.strip_number < 16'(NUM_STRIPS))
                && (in_reg.first_pixel < 16'(PIXELS_PER_STRIP));
        room     = PAINT_W'(PIXELS_PER_STRIP) - in_reg.first_pixel[PAINT_W-1:0];
        cnt      = (npix_reg < NPIX_W'(room)) ? npix_reg[PAINT_W-1:0] : room;

        result = '0;
        if (malformed)
        begin
            result.status = ST_MALFORMED;
        end
        else if (bad_seg)
        begin
            result.status = ST_BAD_SEGMENT;
        end
        else if (stale)
        begin
            result.status = ST_STALE;
        end
        else
        begin
            result.status         = ST_OK;
            result.flush_before   = resync;
            result.duplicate      = seen;
            result.frame_complete = complete;
            if (in_range && (cnt != '0))
            begin
                result.paint_enable = 1'b1;
                result.paint_strip  = in_reg.strip_number;
                result.paint_start  = in_reg.first_pixel;
                result.paint_count  = cnt;
            end
        end

        // the bitmap holds nothing worth keeping once this header resyncs
        sweep_first = (epoch_reg >= EPOCH_LIMIT) && resync && (result.status == ST_OK);

        cur_frame_next = cur_frame_reg;
        count_next     = count_reg;
        epoch_next     = epoch_reg;
        ram_we         = 1'b0;
        ram_waddr      = in_reg.segment_index[SEG_AW-1:0];
        ram_wdata      = epoch_a;
        if (cmd.sweep_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_addr_reg;
            ram_wdata = '0;
            if (&sweep_addr_reg)
            begin
                epoch_next = EPOCH_FIRST;
            end
        end
        else if (cmd.commit && (result.status == ST_OK))
        begin
            ram_we         = !seen;
            cur_frame_next = complete ? in_reg.frame_id + 32'd1 : in_reg.frame_id;
            count_next     = complete ? '0 : (seen ? count_a : count_b);
            epoch_next     = complete ? epoch_a + EPOCH_W'(1) : epoch_a;
        end
    end

    lfst_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_seen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load),
        .raddr (in_data.segment_index[SEG_AW-1:0]),
        .rdata (ram_rdata)
    );

    // an idle sweep waits until no segment of the current frame is marked
    assign dp_status.need_sweep  = (epoch_reg >= EPOCH_LIMIT) && (count_reg == '0);
    assign dp_status.sweep_first = sweep_first;
    assign dp_status.sweep_last  = &sweep_addr_reg;
    assign out_data              = out_reg;

endmodule

/* sv/led_frame_segment_tracker_unit.sv */
// Segment tracker for pixel-packet headers. Each input beat is one decoded header; each
// produces exactly one result beat with a status, the clipped paint range and the
// duplicate, flush and frame-complete flags. Each header is first latched while the
// segment bitmap is read (a registered RAM port), then decided on and the state updated.
// The result lands in an output register, so the next header is taken while it waits.
// The bitmap is cleared by moving to a new epoch mark rather than rewriting it. Once
// after reset, and again when the mark runs high (about every 252 frame restarts), a
// clearing pass writes all 4096 entries, one a cycle. The pass runs while idle once no
// segment of the current frame is marked, so no header is taken meanwhile, or else
// ahead of the next header that resyncs, whose result then waits for the pass to end.
// Register 0 at byte address 0 is stale_window (16 bits, reset 500).
module led_frame_segment_tracker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lfst_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lfst_pkg::out_item_t           out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfst_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import lfst_pkg::*;

    logic [15:0] stale_window_reg;
    ctrl_cmd_t   cmd;
    dp_status_t  dp_status;
    logic        reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_AW-1] == REG_STALE_WIN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_window_reg <= STALE_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            stale_window_reg <= pwdata[15:0];
        end
    end

    assign prdata = reg_hit ? {16'd0, stale_window_reg} : 32'd0;

    lfst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    lfst_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_data),
        .stale_window (stale_window_reg),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .out_data     (out_data)
    );

endmodule
